FILE: rtl/xtea_block_cipher_macros.svh
// ----------------------------------------------------------------------------
// XTEA block cipher assertion macros
// Shared property forms for the checkers of the cipher pipeline.
// ----------------------------------------------------------------------------
`ifndef XTEA_BLOCK_CIPHER_MACROS_SVH
`define XTEA_BLOCK_CIPHER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XTEA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("xtea check failed");

// The consequent must hold in the cycle after the antecedent.
`define XTEA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("xtea check failed");

`endif

FILE: rtl/xtea_pkg.sv
// ----------------------------------------------------------------------------
// XTEA package
// Types, constants and the round mixing function of the XTEA cipher.
// ----------------------------------------------------------------------------
package xtea_pkg;

    localparam logic [31:0] DELTA = 32'h9E3779B9;
    localparam int unsigned KEY_WORDS = 4;
    localparam int unsigned CFG_INDEX_W = 3;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_0 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_1 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_2 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_3 = 3'd3;

    typedef logic [KEY_WORDS-1:0][31:0] t_key;

    typedef struct packed {
        logic        operation;
        logic [31:0] block_first;
        logic [31:0] block_second;
    } t_in_item;

    typedef struct packed {
        logic [31:0] out_first;
        logic [31:0] out_second;
    } t_out_item;

    // State handed from one cell of the chain to the next.
    typedef struct packed {
        logic        op;
        logic [31:0] sum;
        logic [31:0] v0;
        logic [31:0] v1;
    } t_lane;

    function automatic logic [31:0] mix(input logic [31:0] v);
        return ((v << 4) ^ (v >> 5)) + v;
    endfunction

endpackage

FILE: rtl/xtea_half_cell.sv
// ----------------------------------------------------------------------------
// XTEA half-round cell
// One registered half-round of the cipher; cells chain into the full cipher.
// ----------------------------------------------------------------------------
module xtea_half_cell
    import xtea_pkg::*;
#(
    parameter bit SECOND = 1'b0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_lane i_lane,
    input  t_key  i_key,
    output logic  o_valid,
    output t_lane o_lane
);

    logic        upd_v0;
    logic [31:0] src;
    logic [31:0] dst;
    logic [1:0]  key_idx;
    logic [31:0] f_val;
    logic [31:0] dst_new;
    logic        r_valid;
    t_lane       r_lane;
    t_lane       n_lane;

    // Encryption updates v0 in its first half and v1 in its second half;
    // decryption runs the halves in the opposite order.
    always_comb begin
        upd_v0  = (i_lane.op == SECOND);
        src     = upd_v0 ? i_lane.v1 : i_lane.v0;
        dst     = upd_v0 ? i_lane.v0 : i_lane.v1;
        key_idx = upd_v0 ? i_lane.sum[1:0] : i_lane.sum[12:11];
        f_val   = mix(src) ^ (i_lane.sum + i_key[key_idx]);
        dst_new = (i_lane.op == OP_DECRYPT) ? (dst - f_val) : (dst + f_val);

        n_lane = i_lane;
        if (upd_v0) begin
            n_lane.v0 = dst_new;
        end else begin
            n_lane.v1 = dst_new;
        end
        // The running sum steps between the two halves of a round.
        if (!SECOND) begin
            n_lane.sum = (i_lane.op == OP_DECRYPT) ? (i_lane.sum - DELTA)
                                                   : (i_lane.sum + DELTA);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

FILE: rtl/xtea_block_cipher.sv
// ----------------------------------------------------------------------------
// XTEA block cipher
// Pipelined XTEA encrypt/decrypt engine for 64-bit blocks, 128-bit key.
// ----------------------------------------------------------------------------
// The cipher is a chain of 2*ROUNDS half-round cells, each a register stage,
// so one item (a 64-bit block with its operation bit) is accepted every clock
// cycle while the output side does not stall; its result leaves the last cell
// once it has passed through every cell of the chain in order.
// Encrypt and decrypt items may be mixed freely in the chain, since each
// item carries its own operation bit and running sum. The whole chain moves
// as one: it advances whenever the last cell is empty or its result is being
// taken, and it holds every stage while the output is stalled. The key is
// held in four configuration registers and read by all cells directly, so
// the key must only be written while no item is in flight.
module xtea_block_cipher
    import xtea_pkg::*;
#(
    parameter int unsigned ROUNDS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_in_item               i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out_item              o_out_item,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [31:0]            i_cfg_data
);

    localparam int unsigned STAGES = 2 * ROUNDS;
    // Decryption starts from the sum that encryption ends with.
    localparam logic [31:0] DEC_START = 32'(64'(DELTA) * 64'(ROUNDS));

    t_key  r_key;
    logic  chain_en;
    t_lane in_lane;
    logic  stage_valid [STAGES+1];
    t_lane stage_lane  [STAGES+1];

    // Key registers; writes to an index past the last key word are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_KEY_WORD_0: r_key[0] <= i_cfg_data;
                REG_KEY_WORD_1: r_key[1] <= i_cfg_data;
                REG_KEY_WORD_2: r_key[2] <= i_cfg_data;
                REG_KEY_WORD_3: r_key[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The chain moves whenever the result in the last cell is gone or going.
    assign chain_en   = !stage_valid[STAGES] || i_out_ready;
    assign o_in_ready = chain_en;

    always_comb begin
        in_lane.op  = i_in_item.operation;
        in_lane.sum = (i_in_item.operation == OP_DECRYPT) ? DEC_START : 32'd0;
        in_lane.v0  = i_in_item.block_first;
        in_lane.v1  = i_in_item.block_second;
    end

    assign stage_valid[0] = i_in_valid;
    assign stage_lane[0]  = in_lane;

    // Even cells hold the first half of a round, odd cells the second half.
    for (genvar g = 0; g < STAGES; g++) begin : g_cell
        xtea_half_cell #(
            .SECOND (g % 2 == 1)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (chain_en),
            .i_valid (stage_valid[g]),
            .i_lane  (stage_lane[g]),
            .i_key   (r_key),
            .o_valid (stage_valid[g+1]),
            .o_lane  (stage_lane[g+1])
        );
    end

    assign o_out_valid           = stage_valid[STAGES];
    assign o_out_item.out_first  = stage_lane[STAGES].v0;
    assign o_out_item.out_second = stage_lane[STAGES].v1;

endmodule

FILE: rtl/xtea_checker.sv
// ----------------------------------------------------------------------------
// XTEA checker
// Port-level assertions on the cipher's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
`include "xtea_block_cipher_macros.svh"

module xtea_checker
    import xtea_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_in_ready,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input t_out_item              o_out_item
);

    // A result that is not taken stays offered.
    `XTEA_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)

    // A result that is not taken keeps its value.
    `XTEA_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_out_item))

    // The input side is free exactly when the output side does not stall.
    `XTEA_ASSERT_SAME(a_ready_link, 1'b1, o_in_ready == (!o_out_valid || i_out_ready))

    // The chain comes out of reset empty.
    `XTEA_ASSERT_SAME(a_reset_empty, $past(!i_rst_n), !o_out_valid)

endmodule

bind xtea_block_cipher xtea_checker u_xtea_checker (.*);
